[rtl/midi_note_merge_refcount_defines.svh]
// Assertion macros used by the checker file mnm_chk.sv.
`ifndef MIDI_NOTE_MERGE_REFCOUNT_DEFINES_SVH
`define MIDI_NOTE_MERGE_REFCOUNT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define MNM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define MNM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/mnm_pkg.sv]
`default_nettype none
package mnm_pkg;

	localparam int NUM_KEYS_DEF = 128;

	localparam int ACT_W  = 2;
	localparam int KEY_W  = 7;
	localparam int VEL_W  = 7;
	localparam int CHAN_W = 5;
	localparam int CNT_W  = 8;
	localparam int CFG_IDX_W = 1;

	localparam logic [ACT_W-1:0] ACT_KBD    = 2'd0;
	localparam logic [ACT_W-1:0] ACT_PLAYER = 2'd1;
	localparam logic [ACT_W-1:0] ACT_FLUSH  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_CHANNEL = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_TO_CTRL = 1'd1;

	localparam logic [CHAN_W-1:0] CHAN_RESET = 5'd1;
	localparam logic [CNT_W-1:0]  CNT_MAX    = 8'd255;
	localparam logic [CNT_W-1:0]  CNT_ONE    = 8'd1;

	// Outcome of one count update.
	typedef struct packed {
		logic             wr_en;
		logic [CNT_W-1:0] new_cnt;
		logic             emit;
		logic             two;
		logic             first_on;
		logic             zero_vel;
		logic [CNT_W-1:0] first_rep;
	} mnm_dec_t;

endpackage
`default_nettype wire

[rtl/mnm_ram.sv]
`default_nettype none
module mnm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

[rtl/mnm_decide.sv]
`default_nettype none
module mnm_decide (
	input  wire logic [mnm_pkg::ACT_W-1:0] action,
	input  wire logic                      note_on,
	input  wire logic [mnm_pkg::CNT_W-1:0] cnt,
	output mnm_pkg::mnm_dec_t              dec
);
	import mnm_pkg::*;

	always_comb begin
		dec           = '0;
		dec.new_cnt   = cnt;
		dec.first_rep = CNT_ONE;
		case (action)
			ACT_KBD: begin
				dec.wr_en = 1'b1;
				dec.emit  = 1'b1;
				if (note_on) begin
					dec.new_cnt  = CNT_ONE;
					// drop the held note before retriggering it
					dec.two      = (cnt == CNT_ONE);
					dec.first_on = (cnt != CNT_ONE);
				end else begin
					dec.new_cnt = '0;
				end
			end
			ACT_PLAYER: begin
				if (note_on) begin
					if (cnt != CNT_MAX) begin
						dec.wr_en    = 1'b1;
						dec.new_cnt  = cnt + CNT_ONE;
						dec.emit     = (cnt == '0);
						dec.first_on = 1'b1;
					end
				end else if (cnt != '0) begin
					dec.wr_en   = 1'b1;
					dec.new_cnt = cnt - CNT_ONE;
					dec.emit    = (cnt == CNT_ONE);
				end
			end
			ACT_FLUSH: begin
				dec.emit      = (cnt != '0);
				dec.zero_vel  = 1'b1;
				dec.first_rep = cnt;
			end
			default: begin
				dec.emit = 1'b0;
			end
		endcase
	end

endmodule
`default_nettype wire

[rtl/midi_note_merge_refcount.sv]
`default_nettype none
// Note merge with per-key hold counts.
// Input: pulse start with action, note_on, key and velocity while busy is low;
// the transaction is taken on that clock edge and busy rises for its duration.
// Output: each result sits on the result ports for one cycle with strobe high.
// The receiver cannot stall, so results leave on a fixed schedule.
// Configuration: cfg_we with cfg_idx and cfg_data writes output_channel (0) or
// mirror_to_ctrl (1); write only while busy is low and no result is pending.
// The first result is computed from the hold count read on the accepting edge
// and registered onto the result ports; a retrigger's note-on follows in the
// cycle after its note-off. busy stays high over the registered read of the
// hold-count memory and its write-back, and while a keyboard note-on that
// retriggers a key held once sends its note-off and then its note-on.
// Reset: all hold counts read as zero at once (one valid flop per key), the
// channel returns to 1 and mirroring is off; no clearing pass is needed.
// Keys at or above NUM_KEYS and the unused action code give no result.
module midi_note_merge_refcount #(
	parameter int NUM_KEYS = mnm_pkg::NUM_KEYS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [mnm_pkg::ACT_W-1:0]     action,
	input  wire logic                          note_on,
	input  wire logic [mnm_pkg::KEY_W-1:0]     key,
	input  wire logic [mnm_pkg::VEL_W-1:0]     velocity,
	input  wire logic                          cfg_we,
	input  wire logic [mnm_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [mnm_pkg::CHAN_W-1:0]    cfg_data,
	output logic                               strobe,
	output logic                               is_note_on,
	output logic      [mnm_pkg::KEY_W-1:0]     out_key,
	output logic      [mnm_pkg::VEL_W-1:0]     out_velocity,
	output logic      [mnm_pkg::CHAN_W-1:0]    out_channel,
	output logic                               also_ctrl,
	output logic      [mnm_pkg::CNT_W-1:0]     repeat_res,
	output logic                               last
);
	import mnm_pkg::*;

	localparam int AW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
	localparam logic [KEY_W:0] KEY_LIMIT = (KEY_W + 1)'(NUM_KEYS);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_CALC   = 2'd1;
	localparam logic [1:0] ST_SECOND = 2'd2;

	logic [1:0]          state_q;
	logic [CHAN_W-1:0]   chan_q;
	logic                mirror_q;
	logic [NUM_KEYS-1:0] valid_q;

	logic [ACT_W-1:0] act_s1;
	logic             on_s1;
	logic [KEY_W-1:0] key_s1;
	logic [VEL_W-1:0] vel_s1;

	logic             accept;
	logic             in_range;
	logic [AW-1:0]    idx_s1;
	logic [CNT_W-1:0] ram_rdata;
	logic [CNT_W-1:0] cnt;
	logic             wr;
	mnm_dec_t         dec;

	assign accept   = start && !busy;
	assign busy     = (state_q != ST_IDLE);
	assign idx_s1   = key_s1[AW-1:0];
	assign in_range = ({1'b0, key_s1} < KEY_LIMIT);
	// a key never written since reset holds zero
	assign cnt      = (in_range && valid_q[idx_s1]) ? ram_rdata : '0;
	assign wr       = (state_q == ST_CALC) && in_range && dec.wr_en;

	// Hold counts: read on the accepting edge, written back on the edge after it.
	mnm_ram #(
		.WIDTH(CNT_W),
		.DEPTH(NUM_KEYS)
	) u_cnt_ram (
		.clk  (clk),
		.we   (wr),
		.waddr(idx_s1),
		.wdata(dec.new_cnt),
		.re   (accept),
		.raddr(key[AW-1:0]),
		.rdata(ram_rdata)
	);

	mnm_decide u_decide (
		.action (act_s1),
		.note_on(on_s1),
		.cnt    (cnt),
		.dec    (dec)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q   <= CHAN_RESET;
			mirror_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_OUTPUT_CHANNEL: chan_q   <= cfg_data;
				CFG_MIRROR_TO_CTRL: mirror_q <= cfg_data[0];
				default:            chan_q   <= chan_q;
			endcase
		end
	end

	// Sequencer and valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= '0;
			strobe  <= 1'b0;
		end else begin
			strobe <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					if (wr) begin
						valid_q[idx_s1] <= 1'b1;
					end
					strobe  <= in_range && dec.emit;
					state_q <= (in_range && dec.two) ? ST_SECOND : ST_IDLE;
				end
				ST_SECOND: begin
					strobe  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hold the accepted transaction.
	always_ff @(posedge clk) begin
		if (accept) begin
			act_s1 <= action;
			on_s1  <= note_on;
			key_s1 <= key;
			vel_s1 <= velocity;
		end
	end

	// Result payload; the second result of a retrigger is always a note-on.
	always_ff @(posedge clk) begin
		if (state_q == ST_CALC || state_q == ST_SECOND) begin
			out_key     <= key_s1;
			out_channel <= chan_q;
			also_ctrl   <= mirror_q;
			if (state_q == ST_CALC) begin
				is_note_on   <= dec.first_on;
				out_velocity <= dec.zero_vel ? '0 : vel_s1;
				repeat_res   <= dec.first_rep;
				last         <= !dec.two;
			end else begin
				is_note_on   <= 1'b1;
				out_velocity <= vel_s1;
				repeat_res   <= CNT_ONE;
				last         <= 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

[rtl/mnm_chk.sv]
`default_nettype none
`include "midi_note_merge_refcount_defines.svh"
module mnm_chk (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      start,
	input wire logic                      busy,
	input wire logic                      strobe,
	input wire logic                      is_note_on,
	input wire logic                      last,
	input wire logic [mnm_pkg::CNT_W-1:0] repeat_res
);
	import mnm_pkg::*;

	`MNM_ASSERT_NXT(a_busy_after_accept, clk, arst_n, start && !busy, busy,
		"busy did not rise after an accepted transaction")
	`MNM_ASSERT_IMP(a_repeat_nonzero, clk, arst_n, strobe, repeat_res != '0,
		"result with zero repeat count")
	`MNM_ASSERT_IMP(a_first_of_pair, clk, arst_n, strobe && !last,
		!is_note_on && repeat_res == CNT_ONE && busy,
		"first of a result pair is not a single note-off")
	`MNM_ASSERT_NXT(a_pair_follows, clk, arst_n, strobe && !last,
		strobe && last && is_note_on,
		"second result of a retrigger missing or not a final note-on")

endmodule

bind midi_note_merge_refcount mnm_chk u_mnm_chk (.*);
`default_nettype wire
